[design/ffea_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and codes of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

  // operation codes
  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_REINIT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // result codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_BAD   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // register index of total_frames
  localparam logic REG_TOTAL_FRAMES = 1'b0;
  localparam int unsigned TOTAL_RESET = 1048576;

  // sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHDN,
    S_SHUP,
    S_DONE
  } state_t;

  // request word
  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] request_size;
    logic [19:0] frame_address;
  } req_t;

  // response word
  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] granted_address;
    logic [6:0]  extent_count;
  } rsp_t;

endpackage
`default_nettype wire

[design/ffea_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_mem
// Extent table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffea_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 41
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[design/ffea_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_cfg
// Register port holding total_frames.
// ----------------------------------------------------------------------------
module ffea_cfg
  import ffea_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [20:0] total_frames
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TOTAL_FRAMES);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= 21'(TOTAL_RESET);
    end else if (wr_hit) begin
      total_frames <= pwdata[20:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOTAL_FRAMES) begin
      prdata = {11'd0, total_frames};
    end
  end

endmodule
`default_nettype wire

[design/ffea_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_engine
// Sequencer: scans the extent table, decides, shifts entries, reports.
// ----------------------------------------------------------------------------
module ffea_engine
  import ffea_pkg::*;
#(
  parameter int MAX_EXTENTS = 64,
  parameter int FRAME_BITS  = 20
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [20:0]                            total_frames,
  input  wire logic                                   req_valid,
  output logic                                        req_stall,
  input  wire req_t                                   req,
  output logic                                        rsp_valid,
  input  wire logic                                   rsp_stall,
  output rsp_t                                        rsp,
  output logic                                        mem_we,
  output logic [$clog2(MAX_EXTENTS)-1:0]              mem_wr_addr,
  output logic [2*FRAME_BITS:0]                       mem_wr_data,
  output logic [$clog2(MAX_EXTENTS)-1:0]              mem_rd_addr,
  input  wire logic [2*FRAME_BITS:0]                  mem_rd_data
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int FB = FRAME_BITS;
  localparam int LW = FRAME_BITS + 1;
  localparam int TW = (FRAME_BITS + 1 > 21) ? FRAME_BITS + 1 : 21;
  localparam int EW = TW + 1;

  state_t state, state_next;

  logic [TW-1:0] sz;
  logic [FB-1:0] addr;
  logic [EW-1:0] fend;
  logic          op_alloc;
  logic [CW-1:0] cnt, new_cnt;
  logic [CW-1:0] idx, p;
  logic          pend;
  logic [IW-1:0] pend_idx;
  logic [FB-1:0] cur_start, prev_start;
  logic [LW-1:0] cur_len, prev_len;
  logic [1:0]    res_status;
  logic [FB-1:0] res_grant;

  // incoming word decode
  logic [TW-1:0] in_sz, eff_total, lim, tot;
  logic [FB-1:0] in_addr;
  logic [EW-1:0] in_end;
  logic          accept;
  kind_t         in_kind;

  assign in_kind   = kind_t'(req.kind);
  assign in_sz     = TW'(req.request_size);
  assign in_addr   = FB'(req.frame_address);
  assign in_end    = EW'(in_addr) + EW'(in_sz);
  assign lim       = TW'(1) << FB;
  assign tot       = TW'(total_frames);
  assign eff_total = (tot < lim) ? tot : lim;
  assign accept    = req_valid && (state == S_IDLE);
  assign req_stall = (state != S_IDLE);

  // table read word
  logic [FB-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic          hit;

  assign rd_start = mem_rd_data[2*FB:LW];
  assign rd_len   = mem_rd_data[LW-1:0];
  assign hit      = op_alloc ? (TW'(rd_len) >= sz) : (rd_start >= addr);

  // scan end
  logic scan_stop;
  assign scan_stop = (pend && hit) || (idx == cnt);

  // decision on the located position
  logic          has_prev, has_cur, below, above, ovl;
  logic [EW-1:0] prev_end;
  logic [1:0]    dec_status;
  logic [FB-1:0] dec_grant;
  logic          dec_wr;
  logic [IW-1:0] dec_wr_idx;
  logic [2*FB:0] dec_wr_data;
  state_t        dec_next;
  logic [CW-1:0] dec_cnt;

  assign has_prev = (p != '0);
  assign has_cur  = (p < cnt);
  assign prev_end = EW'(prev_start) + EW'(prev_len);
  assign ovl      = (has_prev && (prev_end > EW'(addr)))
                 || (has_cur && (fend > EW'(cur_start)));
  assign below    = has_prev && (prev_end == EW'(addr));
  assign above    = has_cur && (EW'(cur_start) == fend);

  always_comb begin
    dec_status  = ST_OK;
    dec_grant   = '0;
    dec_wr      = 1'b0;
    dec_wr_idx  = p[IW-1:0];
    dec_wr_data = '0;
    dec_next    = S_DONE;
    dec_cnt     = cnt;
    if (op_alloc) begin
      if (!has_cur) begin
        dec_status = ST_NOFIT;
      end else if (TW'(cur_len) == sz) begin
        dec_grant = cur_start;
        dec_next  = S_SHDN;
        dec_cnt   = cnt - 1'b1;
      end else begin
        dec_grant   = cur_start;
        dec_wr      = 1'b1;
        dec_wr_data = {FB'(EW'(cur_start) + EW'(sz)), LW'(TW'(cur_len) - sz)};
      end
    end else if (ovl) begin
      dec_status = ST_BAD;
    end else if (below && above) begin
      dec_wr      = 1'b1;
      dec_wr_idx  = IW'(p - 1'b1);
      dec_wr_data = {prev_start, LW'(EW'(prev_len) + EW'(sz) + EW'(cur_len))};
      dec_next    = S_SHDN;
      dec_cnt     = cnt - 1'b1;
    end else if (below) begin
      dec_wr      = 1'b1;
      dec_wr_idx  = IW'(p - 1'b1);
      dec_wr_data = {prev_start, LW'(EW'(prev_len) + EW'(sz))};
    end else if (above) begin
      dec_wr      = 1'b1;
      dec_wr_data = {addr, LW'(EW'(cur_len) + EW'(sz))};
    end else if (cnt == CW'(MAX_EXTENTS)) begin
      dec_status = ST_FULL;
    end else begin
      dec_next = S_SHUP;
      dec_cnt  = cnt + 1'b1;
    end
  end

  // immediate outcome of an accepted word
  logic in_bad, in_scan;
  always_comb begin
    in_bad  = 1'b0;
    in_scan = 1'b0;
    case (in_kind)
      KIND_ALLOC: begin
        in_bad  = (in_sz == '0);
        in_scan = !in_bad;
      end
      KIND_FREE: begin
        in_bad  = (in_sz == '0) || (in_end > EW'(eff_total));
        in_scan = !in_bad;
      end
      KIND_REINIT: begin
        in_bad = 1'b0;
      end
      default: begin
        in_bad = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:   state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_next = in_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: state_next = dec_next;
      S_SHDN: begin
        if ((idx >= cnt) && !pend) begin
          state_next = S_DONE;
        end
      end
      S_SHUP: begin
        if ((idx == p) && !pend) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_INIT;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = {{FB{1'b0}}, LW'(eff_total)};
    mem_rd_addr = idx[IW-1:0];
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_we = accept && (in_kind == KIND_REINIT);
      end
      S_DECIDE: begin
        mem_we      = dec_wr;
        mem_wr_addr = dec_wr_idx;
        mem_wr_data = dec_wr_data;
      end
      S_SHDN: begin
        mem_we      = pend;
        mem_wr_addr = IW'(pend_idx - 1'b1);
        mem_wr_data = mem_rd_data;
      end
      S_SHUP: begin
        mem_rd_addr = IW'(idx - 1'b1);
        if (pend) begin
          mem_we      = 1'b1;
          mem_wr_addr = IW'(pend_idx + 1'b1);
          mem_wr_data = mem_rd_data;
        end else begin
          mem_we      = (idx == p);
          mem_wr_addr = p[IW-1:0];
          mem_wr_data = {addr, LW'(sz)};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          cnt <= CW'(eff_total != '0);
        end
        S_IDLE: begin
          if (accept) begin
            sz         <= in_sz;
            addr       <= in_addr;
            fend       <= in_end;
            op_alloc   <= (in_kind == KIND_ALLOC);
            idx        <= '0;
            pend       <= 1'b0;
            res_grant  <= '0;
            new_cnt    <= cnt;
            res_status <= in_bad ? ST_BAD : ST_OK;
            if (in_kind == KIND_REINIT) begin
              new_cnt <= CW'(eff_total != '0);
            end
          end
        end
        S_SCAN: begin
          pend     <= (idx < cnt);
          pend_idx <= idx[IW-1:0];
          if (idx < cnt) begin
            idx <= idx + 1'b1;
          end
          if (pend && !hit) begin
            prev_start <= rd_start;
            prev_len   <= rd_len;
          end
          if (pend && hit) begin
            p         <= CW'(pend_idx);
            cur_start <= rd_start;
            cur_len   <= rd_len;
          end else if (idx == cnt) begin
            p <= cnt;
          end
        end
        S_DECIDE: begin
          res_status <= dec_status;
          res_grant  <= dec_grant;
          new_cnt    <= dec_cnt;
          pend       <= 1'b0;
          idx        <= (dec_next == S_SHUP) ? cnt : p + 1'b1;
        end
        S_SHDN: begin
          pend     <= (idx < cnt);
          pend_idx <= idx[IW-1:0];
          if (idx < cnt) begin
            idx <= idx + 1'b1;
          end
        end
        S_SHUP: begin
          pend     <= (idx > p);
          pend_idx <= IW'(idx - 1'b1);
          if (idx > p) begin
            idx <= idx - 1'b1;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            cnt       <= new_cnt;
            rsp_valid <= 1'b1;
            rsp.status          <= res_status;
            rsp.granted_address <= 20'(res_grant);
            rsp.extent_count    <= 7'(new_cnt);
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/first_fit_extent_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit free-extent allocator with coalescing over a sorted extent table.
// ----------------------------------------------------------------------------
// One word is worked at a time. Allocate and free scan the table at one entry
// per cycle through the single read port and stop at the first entry that fits
// or lies at or above the freed range; removing or inserting an entry then
// shifts only the entries above that point, again one per cycle through the
// read-then-write port pair. Reinitialize and rejected words skip the scan.
// After reset the block writes the initial extent before it takes words. A
// finished response waits in its own register while the next request is
// accepted.
module first_fit_extent_allocator
  import ffea_pkg::*;
#(
  parameter int MAX_EXTENTS = 64,
  parameter int FRAME_BITS  = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int DW = 2 * FRAME_BITS + 1;

  logic [20:0]   total_frames;
  logic          mem_we;
  logic [IW-1:0] mem_wr_addr, mem_rd_addr;
  logic [DW-1:0] mem_wr_data, mem_rd_data;

  // configuration register
  ffea_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .total_frames (total_frames)
  );

  // extent table
  ffea_mem #(
    .DEPTH (MAX_EXTENTS),
    .WIDTH (DW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // sequencer
  ffea_engine #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .FRAME_BITS  (FRAME_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .total_frames (total_frames),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .mem_we       (mem_we),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  // an accepted word keeps the request side busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while previous word in flight");

  // only a successful allocate carries a grant
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.granted_address == '0))
    else $error("grant on failed operation");

  // a new response only follows a word in progress
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without a request");

endmodule
`default_nettype wire
